// ===== hdl/command_handshake_sequencer_defines.svh =====
// Assertion macros shared by the command handshake sequencer modules
`ifndef COMMAND_HANDSHAKE_SEQUENCER_DEFINES_SVH
`define COMMAND_HANDSHAKE_SEQUENCER_DEFINES_SVH

// Property sampled on clk, ignored while rst is high
`define CHS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication
`define CHS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define CHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/chs_pkg.sv =====
// Types, codes and result builders for the command handshake sequencer
`timescale 1ns / 1ps
package chs_pkg;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_TRIGGER = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  localparam logic [2:0] DIR_MARK   = 3'd0;
  localparam logic [2:0] DIR_PRESET = 3'd2;
  localparam logic [2:0] DIR_START  = 3'd3;
  localparam logic [2:0] DIR_STOP   = 3'd4;

  localparam logic [1:0] CAR_BUSY  = 2'd2;
  localparam logic [1:0] CAR_ERROR = 2'd3;

  localparam logic [1:0] SRC_INT = 2'd0;
  localparam logic [1:0] SRC_CAD = 2'd1;
  localparam logic [1:0] SRC_CAR = 2'd2;

  localparam logic [7:0] MSG_BLANK      = 8'd0;
  localparam logic [7:0] MSG_NOT_CONN   = 8'd1;
  localparam logic [7:0] MSG_CAD_NORESP = 8'd2;
  localparam logic [7:0] MSG_CAR_NORESP = 8'd3;
  localparam logic [7:0] MSG_TIMEOUT    = 8'd4;

  localparam logic [1:0] KIND_CAR  = 2'd0;
  localparam logic [1:0] KIND_DIR  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd3;

  typedef enum logic [5:0] {
    PH_IDLE        = 6'b000001,
    PH_MARK_RESP   = 6'b000010,
    PH_PRESET_RESP = 6'b000100,
    PH_START_RESP  = 6'b001000,
    PH_STOP_RESP   = 6'b010000,
    PH_CAR_RESP    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [2:0]        directive;
    logic              link_connected;
    logic signed [15:0] cad_value;
    logic [7:0]        cad_message_code;
    logic [1:0]        car_value;
    logic [7:0]        car_message_code;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] dir;
    logic [1:0] car_state;
    logic [1:0] src;
    logic [7:0] code;
  } res_t;

  typedef struct packed {
    logic [1:0] state;
    logic [1:0] src;
    logic [7:0] code;
  } report_t;

  typedef struct packed {
    res_t [2:0] ent;
    logic [1:0] cnt;
  } bundle_t;

  function automatic res_t mk_car(report_t r);
    res_t x;
    x.kind      = KIND_CAR;
    x.dir       = DIR_MARK;
    x.car_state = r.state;
    x.src       = r.src;
    x.code      = r.code;
    return x;
  endfunction

  function automatic res_t mk_done(report_t r);
    res_t x;
    x           = mk_car(r);
    x.kind      = KIND_DONE;
    return x;
  endfunction

  function automatic res_t mk_dir(logic [2:0] d);
    res_t x;
    x.kind      = KIND_DIR;
    x.dir       = d;
    x.car_state = 2'd0;
    x.src       = SRC_INT;
    x.code      = MSG_BLANK;
    return x;
  endfunction

endpackage

// ===== hdl/chs_in_if.sv =====
// Input item channel
`timescale 1ns / 1ps
interface chs_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [2:0]        directive;
  logic              link_connected;
  logic signed [15:0] cad_value;
  logic [7:0]        cad_message_code;
  logic [1:0]        car_value;
  logic [7:0]        car_message_code;

  modport source (output valid, command, directive, link_connected, cad_value,
                  cad_message_code, car_value, car_message_code, input ready);
  modport sink (input valid, command, directive, link_connected, cad_value,
                cad_message_code, car_value, car_message_code, output ready);
endinterface

// ===== hdl/chs_out_if.sv =====
// Result item channel
`timescale 1ns / 1ps
interface chs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [2:0] directive_out;
  logic [1:0] car_state_out;
  logic [1:0] message_source;
  logic [7:0] message_code;
  logic       last;

  modport source (output valid, result_kind, directive_out, car_state_out,
                  message_source, message_code, last, input ready);
  modport sink (input valid, result_kind, directive_out, car_state_out,
                message_source, message_code, last, output ready);
endinterface

// ===== hdl/chs_cfg_if.sv =====
// Configuration write channel for the watchdog length
`timescale 1ns / 1ps
interface chs_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hdl/chs_in_reg.sv =====
// Input register stage
`timescale 1ns / 1ps
module chs_in_reg
  import chs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  in_ready,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic  valid_q;
  item_t item_q;

  assign in_ready   = !valid_q || advance;
  assign item_valid = valid_q;
  assign item       = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_q <= in_item;
    end
  end

endmodule

// ===== hdl/chs_step.sv =====
// Sequencer state, watchdog and result generation for one item
`timescale 1ns / 1ps
`include "command_handshake_sequencer_defines.svh"
module chs_step
  import chs_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  input  item_t       item,
  input  logic        out_free,
  output logic        advance,
  output logic        load,
  output bundle_t     bundle
);

  logic [15:0]           timeout_ticks;
  phase_t                phase, phase_next;
  logic                  trig_used, trig_used_next;
  logic                  enabled, enabled_next;
  logic                  wd_run, wd_run_next;
  logic [TIMER_BITS-1:0] wd_cnt, wd_cnt_next;
  logic [2:0]            held_dir, held_dir_next;
  report_t               rep, rep_next;

  logic [TIMER_BITS+15:0] tmo_wide;
  logic [TIMER_BITS-1:0]  wd_load;
  report_t                r_new;

  assign tmo_wide = {{TIMER_BITS{1'b0}}, timeout_ticks};
  assign wd_load  = tmo_wide[TIMER_BITS-1:0];
  assign advance  = item_valid && out_free;
  assign load     = advance && (bundle.cnt != 2'd0);

  always_comb begin
    phase_next     = phase;
    trig_used_next = trig_used;
    enabled_next   = enabled;
    wd_run_next    = wd_run;
    wd_cnt_next    = wd_cnt;
    held_dir_next  = held_dir;
    rep_next       = rep;
    r_new          = rep;
    bundle         = '0;
    case (item.command)
      CMD_WRITE: begin
        held_dir_next  = item.directive;
        if (item.directive <= DIR_PRESET) begin
          enabled_next = 1'b0;
        end else if (item.directive <= DIR_STOP) begin
          enabled_next = 1'b1;
        end
        trig_used_next = 1'b0;
      end
      CMD_TRIGGER: begin
        if (enabled) begin
          if (phase == PH_IDLE) begin
            if (!trig_used) begin
              trig_used_next = 1'b1;
              r_new          = '{state: CAR_BUSY, src: SRC_INT, code: MSG_BLANK};
              bundle.ent[0]  = mk_car(r_new);
              if (!item.link_connected) begin
                r_new         = '{state: CAR_ERROR, src: SRC_INT, code: MSG_NOT_CONN};
                bundle.ent[1] = mk_car(r_new);
                bundle.ent[2] = mk_done(r_new);
                bundle.cnt    = 2'd3;
              end else begin
                bundle.ent[1] = mk_dir(DIR_MARK);
                bundle.cnt    = 2'd2;
                phase_next    = PH_MARK_RESP;
                wd_run_next   = 1'b1;
                wd_cnt_next   = wd_load;
              end
              rep_next = r_new;
            end
          end else if (trig_used) begin
            wd_run_next = 1'b0;
            case (phase)
              PH_MARK_RESP: begin
                if (held_dir == DIR_START) begin
                  bundle.ent[0] = mk_dir(DIR_START);
                  phase_next    = PH_PRESET_RESP;
                end else begin
                  bundle.ent[0] = mk_dir(DIR_STOP);
                  phase_next    = PH_STOP_RESP;
                end
                bundle.cnt  = 2'd1;
                wd_run_next = 1'b1;
                wd_cnt_next = wd_load;
              end
              PH_PRESET_RESP, PH_START_RESP, PH_STOP_RESP: begin
                if (item.cad_value[15]) begin
                  r_new         = '{state: CAR_ERROR, src: SRC_CAD,
                                    code: item.cad_message_code};
                  bundle.ent[0] = mk_car(r_new);
                  bundle.ent[1] = mk_done(r_new);
                  bundle.cnt    = 2'd2;
                  rep_next      = r_new;
                  phase_next    = PH_IDLE;
                end else begin
                  phase_next  = (phase == PH_PRESET_RESP) ? PH_START_RESP : PH_CAR_RESP;
                  wd_run_next = 1'b1;
                  wd_cnt_next = wd_load;
                end
              end
              default: begin
                if (item.car_value == CAR_BUSY) begin
                  r_new = '{state: CAR_BUSY, src: SRC_INT, code: MSG_BLANK};
                end else begin
                  r_new = '{state: item.car_value, src: SRC_CAR,
                            code: item.car_message_code};
                end
                bundle.ent[0] = mk_car(r_new);
                bundle.ent[1] = mk_done(r_new);
                bundle.cnt    = 2'd2;
                rep_next      = r_new;
                phase_next    = PH_IDLE;
              end
            endcase
          end
        end
      end
      CMD_TICK: begin
        if (wd_run) begin
          if (wd_cnt > TIMER_BITS'(1)) begin
            wd_cnt_next = wd_cnt - TIMER_BITS'(1);
          end else begin
            wd_cnt_next = '0;
            wd_run_next = 1'b0;
            case (phase)
              PH_MARK_RESP, PH_PRESET_RESP, PH_START_RESP, PH_STOP_RESP: begin
                r_new = '{state: CAR_ERROR, src: SRC_INT, code: MSG_CAD_NORESP};
              end
              PH_CAR_RESP: begin
                r_new = '{state: CAR_ERROR, src: SRC_INT, code: MSG_CAR_NORESP};
              end
              default: begin
                r_new = '{state: CAR_ERROR, src: SRC_INT, code: MSG_TIMEOUT};
              end
            endcase
            bundle.ent[0] = mk_car(r_new);
            bundle.ent[1] = mk_done(r_new);
            bundle.cnt    = 2'd2;
            rep_next      = r_new;
            phase_next    = PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      phase         <= PH_IDLE;
      trig_used     <= 1'b1;
      enabled       <= 1'b0;
      wd_run        <= 1'b0;
      wd_cnt        <= '0;
      held_dir      <= DIR_MARK;
      rep           <= '{state: 2'd0, src: SRC_INT, code: MSG_BLANK};
    end else begin
      if (cfg_wr) begin
        timeout_ticks <= cfg_data;
      end
      if (advance) begin
        phase     <= phase_next;
        trig_used <= trig_used_next;
        enabled   <= enabled_next;
        wd_run    <= wd_run_next;
        wd_cnt    <= wd_cnt_next;
        held_dir  <= held_dir_next;
        rep       <= rep_next;
      end
    end
  end

  `CHS_ASSERT_IMPL(a_wd_not_idle, wd_run, phase != PH_IDLE, "watchdog running while idle")
  `CHS_ASSERT_NEXT(a_disabled_idle, (phase == PH_IDLE) && !enabled, phase == PH_IDLE, "left idle while disabled")

endmodule

// ===== hdl/chs_out_seq.sv =====
// Result register: emits the beats of one item's results, one per cycle while out_ready is high
`timescale 1ns / 1ps
`include "command_handshake_sequencer_defines.svh"
module chs_out_seq
  import chs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  bundle_t bundle,
  output logic    out_free,
  output logic    out_valid,
  input  logic    out_ready,
  output res_t    out_res,
  output logic    out_last
);

  logic    valid_q;
  bundle_t bundle_q;
  logic [1:0] idx;
  logic    take;

  assign out_valid = valid_q;
  assign out_last  = (idx == (bundle_q.cnt - 2'd1));
  assign take      = valid_q && out_ready;
  assign out_free  = !valid_q || (take && out_last);

  always_comb begin
    case (idx)
      2'd1:    out_res = bundle_q.ent[1];
      2'd2:    out_res = bundle_q.ent[2];
      default: out_res = bundle_q.ent[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
      idx     <= 2'd0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx     <= 2'd0;
    end else if (take && out_last) begin
      valid_q <= 1'b0;
      idx     <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bundle_q <= bundle;
    end
  end

  `CHS_ASSERT_IMPL(a_idx_range, valid_q, (idx < bundle_q.cnt) && (bundle_q.cnt != 2'd0), "beat index out of range")
  `CHS_ASSERT_IMPL(a_load_free, load, out_free, "result register overwritten")
  `CHS_ASSERT_NEXT(a_load_idx, load, valid_q && (idx == 2'd0), "load did not restart beat index")

endmodule

// ===== hdl/command_handshake_sequencer.sv =====
// The first result beat passes the input register, then the result register, which
// holds items back while busy. Throughput: one input item per cycle while the result
// register is free; an item with n results (up to 3) holds it until its n beats are taken.
// Reset (rst, synchronous): idle, disabled, watchdog stopped, timeout 3 ticks.
// Configuration writes are always taken (ready held high).
`timescale 1ns / 1ps
module command_handshake_sequencer
  import chs_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input logic   clk,
  input logic   rst,
  chs_in_if.sink    item,
  chs_out_if.source result,
  chs_cfg_if.sink   cfg
);

  item_t   in_item;
  item_t   item_r;
  logic    item_valid;
  logic    advance;
  logic    load;
  logic    out_free;
  bundle_t bundle;
  res_t    out_res;

  assign in_item = '{command: item.command, directive: item.directive,
                     link_connected: item.link_connected, cad_value: item.cad_value,
                     cad_message_code: item.cad_message_code, car_value: item.car_value,
                     car_message_code: item.car_message_code};

  assign cfg.ready = 1'b1;

  chs_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (item.valid),
    .in_item    (in_item),
    .in_ready   (item.ready),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item_r)
  );

  chs_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg.valid),
    .cfg_data   (cfg.data),
    .item_valid (item_valid),
    .item       (item_r),
    .out_free   (out_free),
    .advance    (advance),
    .load       (load),
    .bundle     (bundle)
  );

  chs_out_seq u_out_seq (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .bundle    (bundle),
    .out_free  (out_free),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_res   (out_res),
    .out_last  (result.last)
  );

  assign result.result_kind    = out_res.kind;
  assign result.directive_out  = out_res.dir;
  assign result.car_state_out  = out_res.car_state;
  assign result.message_source = out_res.src;
  assign result.message_code   = out_res.code;

endmodule

// ===== verif/command_handshake_sequencer_tb.sv =====
// Self-checking testbench for the command handshake sequencer: directed table, then random sequences
`timescale 1ns / 1ps
module command_handshake_sequencer_tb;
  import chs_pkg::*;

  typedef struct packed {
    res_t r;
    logic last;
  } beat_t;

  typedef struct packed {
    item_t      it;
    int         nfix;
    res_t [2:0] fix;
  } row_t;

  localparam res_t R_BUSY      = '{KIND_CAR, 3'd0, CAR_BUSY, SRC_INT, MSG_BLANK};
  localparam res_t R_BUSY_END  = '{KIND_DONE, 3'd0, CAR_BUSY, SRC_INT, MSG_BLANK};
  localparam res_t R_NC        = '{KIND_CAR, 3'd0, CAR_ERROR, SRC_INT, MSG_NOT_CONN};
  localparam res_t R_NC_END    = '{KIND_DONE, 3'd0, CAR_ERROR, SRC_INT, MSG_NOT_CONN};
  localparam res_t R_MARK      = '{KIND_DIR, DIR_MARK, 2'd0, SRC_INT, MSG_BLANK};
  localparam res_t R_START     = '{KIND_DIR, DIR_START, 2'd0, SRC_INT, MSG_BLANK};
  localparam res_t R_STOP      = '{KIND_DIR, DIR_STOP, 2'd0, SRC_INT, MSG_BLANK};
  localparam res_t R_CAD_TO    = '{KIND_CAR, 3'd0, CAR_ERROR, SRC_INT, MSG_CAD_NORESP};
  localparam res_t R_CAD_TO_END = '{KIND_DONE, 3'd0, CAR_ERROR, SRC_INT, MSG_CAD_NORESP};
  localparam res_t R_REJ       = '{KIND_CAR, 3'd0, CAR_ERROR, SRC_CAD, 8'hff};
  localparam res_t R_REJ_END   = '{KIND_DONE, 3'd0, CAR_ERROR, SRC_CAD, 8'hff};

  logic clk;
  logic rst;

  chs_in_if  in_ch ();
  chs_out_if out_ch ();
  chs_cfg_if cfg_ch ();

  command_handshake_sequencer #(.TIMER_BITS(16)) u_top (
    .clk(clk),
    .rst(rst),
    .item(in_ch),
    .result(out_ch),
    .cfg(cfg_ch)
  );

  int fail_count = 0;
  int sent = 0;
  int burst_left = 0;
  int hold_reqs = 0;
  int tmo_now = TIMEOUT_RESET;

  row_t  plan_rows[$];
  row_t  sent_rows[$];
  beat_t due_beats[$];
  beat_t new_beats[$];

  // sequencer state as predicted
  phase_t      ph;
  logic        trig_taken;
  logic        armed;
  logic        dog_on;
  logic [15:0] dog_cnt;
  logic [15:0] timeout;
  logic [2:0]  held;
  report_t     shown;

  function automatic void emit(logic [1:0] kind, logic [2:0] d, report_t rep);
    beat_t b;
    b.r.kind      = kind;
    b.r.dir       = d;
    b.r.car_state = rep.state;
    b.r.src       = rep.src;
    b.r.code      = rep.code;
    b.last        = 1'b0;
    new_beats.push_back(b);
  endfunction

  function automatic void report_car(logic [1:0] st, logic [1:0] src, logic [7:0] code);
    shown.state = st;
    shown.src   = src;
    shown.code  = code;
    emit(KIND_CAR, 3'd0, shown);
  endfunction

  function automatic void complete();
    ph = PH_IDLE;
    emit(KIND_DONE, 3'd0, shown);
  endfunction

  function automatic void arm_dog();
    dog_on  = 1'b1;
    dog_cnt = timeout;
  endfunction

  function automatic void seq_trigger(item_t it);
    if (!armed) return;
    if (ph == PH_IDLE) begin
      if (trig_taken) return;
      trig_taken = 1'b1;
      report_car(CAR_BUSY, SRC_INT, MSG_BLANK);
      if (!it.link_connected) begin
        report_car(CAR_ERROR, SRC_INT, MSG_NOT_CONN);
        complete();
      end else begin
        emit(KIND_DIR, DIR_MARK, '0);
        ph = PH_MARK_RESP;
        arm_dog();
      end
      return;
    end
    if (!trig_taken) return;
    dog_on = 1'b0;
    case (ph)
      PH_MARK_RESP: begin
        if (held == DIR_START) begin
          emit(KIND_DIR, DIR_START, '0);
          ph = PH_PRESET_RESP;
        end else begin
          emit(KIND_DIR, DIR_STOP, '0);
          ph = PH_STOP_RESP;
        end
        arm_dog();
      end
      PH_PRESET_RESP, PH_START_RESP, PH_STOP_RESP: begin
        if (it.cad_value[15]) begin
          report_car(CAR_ERROR, SRC_CAD, it.cad_message_code);
          complete();
        end else begin
          if (ph == PH_PRESET_RESP) ph = PH_START_RESP;
          else ph = PH_CAR_RESP;
          arm_dog();
        end
      end
      default: begin
        if (it.car_value == CAR_BUSY) report_car(CAR_BUSY, SRC_INT, MSG_BLANK);
        else report_car(it.car_value, SRC_CAR, it.car_message_code);
        complete();
      end
    endcase
  endfunction

  function automatic void seq_tick();
    logic [7:0] why;
    if (!dog_on) return;
    if (dog_cnt > 16'd1) begin
      dog_cnt = dog_cnt - 16'd1;
      return;
    end
    dog_cnt = '0;
    dog_on  = 1'b0;
    case (ph)
      PH_MARK_RESP, PH_PRESET_RESP, PH_START_RESP, PH_STOP_RESP: why = MSG_CAD_NORESP;
      PH_CAR_RESP: why = MSG_CAR_NORESP;
      default: why = MSG_TIMEOUT;
    endcase
    report_car(CAR_ERROR, SRC_INT, why);
    complete();
  endfunction

  function automatic void step_sequencer(item_t it);
    new_beats.delete();
    case (it.command)
      CMD_WRITE: begin
        held = it.directive;
        if (it.directive <= DIR_PRESET) armed = 1'b0;
        else if (it.directive <= DIR_STOP) armed = 1'b1;
        trig_taken = 1'b0;
      end
      CMD_TRIGGER: seq_trigger(it);
      CMD_TICK: seq_tick();
      default: ;
    endcase
    if (new_beats.size() != 0) new_beats[new_beats.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // scoreboard
  always @(posedge clk) begin
    item_t got;
    row_t  row;
    beat_t want;
    beat_t b;
    if (rst) begin
      ph         = PH_IDLE;
      trig_taken = 1'b1;
      armed      = 1'b0;
      dog_on     = 1'b0;
      dog_cnt    = '0;
      timeout    = TIMEOUT_RESET;
      held       = DIR_MARK;
      shown      = '0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_beats.size() == 0) begin
          $display("%0t unexpected result beat: kind %0d code %0d", $time,
                   out_ch.result_kind, out_ch.message_code);
          fail_count++;
        end else begin
          want = due_beats.pop_front();
          check_field("result_kind", want.r.kind, out_ch.result_kind);
          check_field("directive_out", want.r.dir, out_ch.directive_out);
          check_field("car_state_out", want.r.car_state, out_ch.car_state_out);
          check_field("message_source", want.r.src, out_ch.message_source);
          check_field("message_code", want.r.code, out_ch.message_code);
          check_field("last", want.last, out_ch.last);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) timeout = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        got.command          = in_ch.command;
        got.directive        = in_ch.directive;
        got.link_connected   = in_ch.link_connected;
        got.cad_value        = in_ch.cad_value;
        got.cad_message_code = in_ch.cad_message_code;
        got.car_value        = in_ch.car_value;
        got.car_message_code = in_ch.car_message_code;
        row = sent_rows.pop_front();
        step_sequencer(got);
        if (row.nfix < 0) begin
          foreach (new_beats[i]) due_beats.push_back(new_beats[i]);
        end else begin
          for (int i = 0; i < row.nfix; i++) begin
            b.r    = row.fix[i];
            b.last = (i == row.nfix - 1);
            due_beats.push_back(b);
          end
        end
      end
    end
  end

  function automatic item_t rnd_item(logic [1:0] cmd);
    item_t it;
    it.command          = cmd;
    it.directive        = 3'($urandom_range(0, 7));
    it.link_connected   = 1'($urandom_range(0, 1));
    it.cad_value        = 16'($urandom);
    it.cad_message_code = 8'($urandom);
    it.car_value        = 2'($urandom_range(0, 3));
    it.car_message_code = 8'($urandom);
    return it;
  endfunction

  function automatic item_t wr(logic [2:0] d);
    item_t it;
    it = rnd_item(CMD_WRITE);
    it.directive = d;
    return it;
  endfunction

  function automatic item_t trig(logic link);
    item_t it;
    it = rnd_item(CMD_TRIGGER);
    it.link_connected = link;
    return it;
  endfunction

  function automatic item_t cad_reply(logic [15:0] v, logic [7:0] code);
    item_t it;
    it = rnd_item(CMD_TRIGGER);
    it.cad_value        = v;
    it.cad_message_code = code;
    return it;
  endfunction

  function automatic item_t car_reply(logic [1:0] st, logic [7:0] code);
    item_t it;
    it = rnd_item(CMD_TRIGGER);
    it.car_value        = st;
    it.car_message_code = code;
    return it;
  endfunction

  // trigger carrying a CAD reply, mostly accepted
  function automatic item_t reply();
    item_t it;
    it = rnd_item(CMD_TRIGGER);
    if ($urandom_range(0, 5) != 0) it.cad_value[15] = 1'b0;
    return it;
  endfunction

  task automatic add_row(item_t it, int n, res_t a = '0, res_t b = '0, res_t c = '0);
    row_t r;
    r.it     = it;
    r.nfix   = n;
    r.fix[0] = a;
    r.fix[1] = b;
    r.fix[2] = c;
    plan_rows.push_back(r);
  endtask

  task automatic send_row(row_t r);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_ch.valid            <= 1'b1;
    in_ch.command          <= r.it.command;
    in_ch.directive        <= r.it.directive;
    in_ch.link_connected   <= r.it.link_connected;
    in_ch.cad_value        <= r.it.cad_value;
    in_ch.cad_message_code <= r.it.cad_message_code;
    in_ch.car_value        <= r.it.car_value;
    in_ch.car_message_code <= r.it.car_message_code;
    sent_rows.push_back(r);
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    burst_left--;
    if (burst_left == 0) in_ch.valid <= 1'b0;
  endtask

  task automatic play(item_t it);
    row_t r;
    r.it   = it;
    r.nfix = -1;
    r.fix  = '0;
    send_row(r);
  endtask

  task automatic wait_drained();
    if (burst_left != 0) in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (due_beats.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    tmo_now = v;
  endtask

  task automatic spin_ticks(bit clean);
    int lim;
    int n;
    lim = (tmo_now == 0) ? 1 : tmo_now;
    if (!clean && lim <= 8 && $urandom_range(0, 5) == 0) n = lim;
    else n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) play(rnd_item(CMD_TICK));
  endtask

  // directive write followed by a full run of triggers; noise only when not clean
  task automatic random_sequence(bit clean);
    int pick;
    logic [2:0] d;
    pick = $urandom_range(0, 9);
    if (pick < 4) d = DIR_START;
    else if (pick < 8 || clean) d = DIR_STOP;
    else d = 3'($urandom_range(0, 7));
    play(wr(d));
    spin_ticks(clean);
    play(trig($urandom_range(0, 9) != 0));
    repeat (4) begin
      spin_ticks(clean);
      if (!clean && $urandom_range(0, 11) == 0) play(rnd_item(2'($urandom_range(0, 3))));
      play(reply());
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin
    int hold_left;
    int seen;
    int mode;
    int mode_left;
    hold_left = 0;
    seen      = 0;
    mode      = 0;
    mode_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != seen) begin
        seen      = hold_reqs;
        hold_left = 300;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin
    logic [15:0] plan_tmo [6];
    int goal;
    rst                    <= 1'b1;
    in_ch.valid            <= 1'b0;
    in_ch.command          <= '0;
    in_ch.directive        <= '0;
    in_ch.link_connected   <= 1'b0;
    in_ch.cad_value        <= '0;
    in_ch.cad_message_code <= '0;
    in_ch.car_value        <= '0;
    in_ch.car_message_code <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.data            <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    add_row('0, 0);
    add_row(trig(1'b1), 0);
    add_row('1, 0);
    add_row(wr(DIR_START), 0);
    add_row(trig(1'b0), 3, R_BUSY, R_NC, R_NC_END);
    add_row(wr(DIR_STOP), 0);
    add_row(trig(1'b1), 2, R_BUSY, R_MARK);
    add_row(rnd_item(CMD_TICK), 0);
    add_row(rnd_item(CMD_TICK), 0);
    add_row(rnd_item(CMD_TICK), 2, R_CAD_TO, R_CAD_TO_END);
    add_row(wr(DIR_START), 0);
    add_row(trig(1'b1), 2, R_BUSY, R_MARK);
    add_row(trig(1'b1), 1, R_START);
    add_row(cad_reply(16'h7fff, 8'h00), 0);
    add_row(cad_reply(16'h0000, 8'h00), 0);
    add_row(car_reply(CAR_BUSY, 8'hff), 2, R_BUSY, R_BUSY_END);
    add_row(wr(3'd7), 0);
    add_row(trig(1'b1), 2, R_BUSY, R_MARK);
    add_row(trig(1'b1), 1, R_STOP);
    add_row(cad_reply(16'h8000, 8'hff), 2, R_REJ, R_REJ_END);
    add_row(wr(DIR_STOP), 0);
    add_row(trig(1'b1), 2, R_BUSY, R_MARK);
    // stale trigger after a new write; the watchdog still expires
    add_row(wr(DIR_STOP), 0);
    add_row(trig(1'b1), 0);
    add_row(rnd_item(CMD_TICK), 0);
    add_row(rnd_item(CMD_TICK), 0);
    add_row(rnd_item(CMD_TICK), 2, R_CAD_TO, R_CAD_TO_END);
    foreach (plan_rows[i]) send_row(plan_rows[i]);

    plan_tmo[0] = 16'd1;
    plan_tmo[1] = 16'd0;
    plan_tmo[2] = 16'd2;
    plan_tmo[3] = 16'($urandom_range(1, 6));
    plan_tmo[4] = TIMEOUT_RESET;
    plan_tmo[5] = 16'hffff;
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_timeout(plan_tmo[p]);
      if (p == 2) hold_reqs <= hold_reqs + 1;
      goal = sent + 72;
      while (sent < goal) random_sequence(p == 5);
    end
    wait_drained();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== command_handshake_sequencer.f =====
+incdir+hdl
hdl/chs_pkg.sv
hdl/chs_in_if.sv
hdl/chs_out_if.sv
hdl/chs_cfg_if.sv
hdl/chs_in_reg.sv
hdl/chs_step.sv
hdl/chs_out_seq.sv
hdl/command_handshake_sequencer.sv
verif/command_handshake_sequencer_tb.sv
